// ===== hw/rtl/mpg_pkg.sv =====
package mpg_pkg;

    localparam int BYTE_BITS        = 48;
    localparam int TIME_BITS        = 40;
    localparam int TICKS_PER_SECOND = 1000;
    localparam int RET_BITS         = 7;
    localparam int CNT_BITS         = 2;
    localparam int CFG_INDEX_BITS   = 3;

    typedef logic [BYTE_BITS-1:0] bytes_t;
    typedef logic [TIME_BITS-1:0] ticks_t;
    typedef logic [RET_BITS-1:0]  ret_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    localparam bytes_t BYTE_MAX = '1;

    // swap growth bar: 4 MiB per whole second, at least 16 MiB, a quarter while sustaining
    localparam int     GROWTH_SHIFT       = 22;
    localparam int     SUSTAIN_SHIFT      = 2;
    localparam bytes_t GROWTH_MIN         = BYTE_BITS'(64'd16777216);
    localparam bytes_t GROWTH_MIN_SUSTAIN = GROWTH_MIN >> SUSTAIN_SHIFT;
    localparam bytes_t SAT_BAR_SUSTAIN    = BYTE_MAX >> SUSTAIN_SHIFT;

    // elapsed ticks from which the per-second rate product saturates
    localparam logic [63:0] SAT_TICKS =
        (64'd1 << (BYTE_BITS - GROWTH_SHIFT)) * 64'(TICKS_PER_SECOND);

    localparam int Q_BITS   = BYTE_BITS - GROWTH_SHIFT + SUSTAIN_SHIFT + 1;
    localparam int LIM_BITS = Q_BITS + $clog2(TICKS_PER_SECOND) + 1;
    localparam int CMP_BITS = (LIM_BITS > TIME_BITS) ? LIM_BITS : TIME_BITS;

    localparam ticks_t RECOVERY_TICKS = TIME_BITS'(64'd10 * 64'(TICKS_PER_SECOND));
    localparam ticks_t CHANGE_TICKS   = TIME_BITS'(64'd5 * 64'(TICKS_PER_SECOND));

    localparam ret_t RET_10  = 7'd10;
    localparam ret_t RET_25  = 7'd25;
    localparam ret_t RET_50  = 7'd50;
    localparam ret_t RET_100 = 7'd100;
    localparam cnt_t CNT_MAX = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHYSICAL    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RESERVE     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOTAL       = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FLOOR       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_CAP = 3'd4;

    localparam int IN_FIELD_BITS  = 3 * BYTE_BITS + TIME_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 4 + RET_BITS + BYTE_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

    typedef struct packed {
        bytes_t physical;
        bytes_t reserve;
        bytes_t total;
        bytes_t floor_bytes;
    } cfg_t;

    typedef struct packed {
        logic   free_valid;
        bytes_t free_bytes;
        logic   swap_present;
        bytes_t swap_used_bytes;
        bytes_t retained_total;
        ticks_t now_ms;
    } sample_t;

    // per-sample facts that need no governor state
    typedef struct packed {
        logic   free_valid;
        logic   mem_low;
        logic   swap_present;
        logic   grow_entry;
        logic   grow_sustain;
        ticks_t now_ms;
    } tag_t;

    typedef struct packed {
        tag_t   tag;
        bytes_t target;
    } prep_t;

    typedef struct packed {
        logic   memory_pressure;
        logic   swap_pressure;
        logic   memory_notice;
        logic   swap_notice;
        ret_t   retention_percent;
        bytes_t effective_cap;
    } result_t;

endpackage

// ===== hw/rtl/mpg_prep.sv =====
module mpg_prep (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  mpg_pkg::sample_t in_sample,
    input  mpg_pkg::cfg_t    cfg,
    output logic             out_valid,
    output mpg_pkg::prep_t   out_prep
);

    localparam int STAGES = 7;

    logic [STAGES-1:0] valid_reg;

    mpg_pkg::sample_t s0_reg;

    // swap baseline, tracks the previous sample with swap present
    logic            base_valid_reg;
    mpg_pkg::bytes_t base_used_reg;
    mpg_pkg::ticks_t base_time_reg;

    mpg_pkg::tag_t   s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg, s5_tag_reg, s6_tag_reg;
    mpg_pkg::bytes_t s1_sum_reg, s2_sum_reg, s3_sum_reg;
    logic            s1_observe_reg;
    mpg_pkg::bytes_t s1_growth_reg;
    mpg_pkg::ticks_t s1_dt_reg;
    mpg_pkg::bytes_t s2_q_reg, s3_q_reg, s4_q_reg;
    logic [7:0]      s4_r_reg;
    mpg_pkg::bytes_t s5_f45_reg;
    mpg_pkg::bytes_t s6_target_reg;

    // stage 1 logic
    logic [mpg_pkg::BYTE_BITS:0] sum_wide;
    mpg_pkg::bytes_t             sum_next;
    logic                        rebase;

    // stage 2 logic
    mpg_pkg::bytes_t             qa, qb;
    logic [mpg_pkg::Q_BITS-1:0]  qe, qs;
    logic [mpg_pkg::LIM_BITS-1:0] lim_e, lim_s;
    logic [mpg_pkg::CMP_BITS-1:0] dt_c;
    logic                         rate_sat;
    logic                         grow_e, grow_s;

    // stage 3 and 4 logic
    mpg_pkg::bytes_t qc, qd, qf;
    logic [7:0]      r_next;

    // stage 5 logic
    logic [15:0]     r_scaled;
    logic [3:0]      r_div;
    logic [7:0]      r_rem;
    logic [7:0]      r_low;
    mpg_pkg::bytes_t f45_next;

    // stage 6 logic
    mpg_pkg::bytes_t base_cap, t_free, target_next;

    always_comb
    begin
        sum_wide = {1'b0, s0_reg.free_bytes} + {1'b0, s0_reg.retained_total};
        sum_next = sum_wide[mpg_pkg::BYTE_BITS] ? mpg_pkg::BYTE_MAX
                                                : sum_wide[mpg_pkg::BYTE_BITS-1:0];
        rebase   = !base_valid_reg || (s0_reg.now_ms <= base_time_reg) ||
                   (s0_reg.swap_used_bytes < base_used_reg);
    end

    always_comb
    begin
        qa = (s1_sum_reg >> 3) + (s1_sum_reg >> 4);
        qb = qa + (qa >> 4);

        // growth >= secs << k  <=>  dt < ((growth >> k) + 1) * ticks per second
        qe    = mpg_pkg::Q_BITS'(s1_growth_reg >> mpg_pkg::GROWTH_SHIFT) + 1'b1;
        qs    = mpg_pkg::Q_BITS'(s1_growth_reg >>
                                 (mpg_pkg::GROWTH_SHIFT - mpg_pkg::SUSTAIN_SHIFT)) + 1'b1;
        lim_e = mpg_pkg::LIM_BITS'(qe) * mpg_pkg::LIM_BITS'(mpg_pkg::TICKS_PER_SECOND);
        lim_s = mpg_pkg::LIM_BITS'(qs) * mpg_pkg::LIM_BITS'(mpg_pkg::TICKS_PER_SECOND);
        dt_c  = mpg_pkg::CMP_BITS'(s1_dt_reg);
        rate_sat = 64'(s1_dt_reg) >= mpg_pkg::SAT_TICKS;

        grow_e = s1_observe_reg && (s1_growth_reg >= mpg_pkg::GROWTH_MIN) &&
                 (rate_sat ? (s1_growth_reg == mpg_pkg::BYTE_MAX)
                           : (dt_c < mpg_pkg::CMP_BITS'(lim_e)));
        grow_s = s1_observe_reg && (s1_growth_reg >= mpg_pkg::GROWTH_MIN_SUSTAIN) &&
                 (rate_sat ? (s1_growth_reg >= mpg_pkg::SAT_BAR_SUSTAIN)
                           : (dt_c < mpg_pkg::CMP_BITS'(lim_s)));
    end

    always_comb
    begin
        qc = s2_q_reg + (s2_q_reg >> 8);
        qd = qc + (qc >> 16);
        qf = s3_q_reg + (s3_q_reg >> 32);
        // quotient underestimates sum/5 by a few units; remainder fits in 8 bits
        r_next = s3_sum_reg[7:0] - (qf[7:0] + {qf[5:0], 2'b00});
    end

    always_comb
    begin
        r_scaled = 16'(s4_r_reg) * 16'd205;
        r_div    = r_scaled[13:10];
        r_rem    = s4_r_reg - (8'(r_div) + {2'b00, r_div, 2'b00});
        // floor(4 * sum / 5) = 4 * q + floor(4 * rem / 5)
        r_low    = {2'b00, r_div, 2'b00} + ((r_rem == 8'd0) ? 8'd0 : (r_rem - 8'd1));
        f45_next = (s4_q_reg << 2) + mpg_pkg::BYTE_BITS'(r_low);
    end

    always_comb
    begin
        base_cap = cfg.total;
        if (cfg.physical != '0 && (cfg.physical >> 1) < cfg.total)
        begin
            base_cap = cfg.physical >> 1;
        end
        t_free = (s5_tag_reg.free_valid && s5_f45_reg < base_cap) ? s5_f45_reg : base_cap;
        target_next = (t_free < cfg.floor_bytes) ? cfg.floor_bytes : t_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            base_valid_reg <= 1'b0;
            base_used_reg  <= '0;
            base_time_reg  <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
            if (valid_reg[0])
            begin
                if (s0_reg.swap_present)
                begin
                    base_valid_reg <= 1'b1;
                    base_used_reg  <= s0_reg.swap_used_bytes;
                    base_time_reg  <= s0_reg.now_ms;
                end
                else
                begin
                    base_valid_reg <= 1'b0;
                    base_used_reg  <= '0;
                    base_time_reg  <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg <= in_sample;

            s1_tag_reg.free_valid   <= s0_reg.free_valid;
            s1_tag_reg.mem_low      <= s0_reg.free_bytes < cfg.reserve;
            s1_tag_reg.swap_present <= s0_reg.swap_present;
            s1_tag_reg.grow_entry   <= 1'b0;
            s1_tag_reg.grow_sustain <= 1'b0;
            s1_tag_reg.now_ms       <= s0_reg.now_ms;
            s1_sum_reg     <= sum_next;
            s1_observe_reg <= s0_reg.swap_present && !rebase;
            s1_growth_reg  <= s0_reg.swap_used_bytes - base_used_reg;
            s1_dt_reg      <= s0_reg.now_ms - base_time_reg;

            s2_tag_reg <= {s1_tag_reg.free_valid, s1_tag_reg.mem_low,
                           s1_tag_reg.swap_present, grow_e, grow_s, s1_tag_reg.now_ms};
            s2_sum_reg <= s1_sum_reg;
            s2_q_reg   <= qb;

            s3_tag_reg <= s2_tag_reg;
            s3_sum_reg <= s2_sum_reg;
            s3_q_reg   <= qd;

            s4_tag_reg <= s3_tag_reg;
            s4_q_reg   <= qf;
            s4_r_reg   <= r_next;

            s5_tag_reg <= s4_tag_reg;
            s5_f45_reg <= f45_next;

            s6_tag_reg    <= s5_tag_reg;
            s6_target_reg <= target_next;
        end
    end

    assign out_valid       = valid_reg[STAGES-1];
    assign out_prep.tag    = s6_tag_reg;
    assign out_prep.target = s6_target_reg;

endmodule

// ===== hw/rtl/mpg_state.sv =====
module mpg_state (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  mpg_pkg::prep_t    pin,
    input  logic              cap_load,
    input  mpg_pkg::bytes_t   cap_load_value,
    output logic              out_valid,
    output mpg_pkg::result_t  out_result
);

    logic            mem_flag_reg, mem_flag_next;
    logic            swap_flag_reg, swap_flag_next;
    mpg_pkg::cnt_t   count_reg, count_next;
    mpg_pkg::ret_t   retention_reg, retention_next;
    logic            recovery_valid_reg, recovery_valid_next;
    mpg_pkg::ticks_t recovery_time_reg, recovery_time_next;
    logic            change_valid_reg, change_valid_next;
    mpg_pkg::ticks_t change_time_reg, change_time_next;
    mpg_pkg::bytes_t cap_reg, cap_next;

    logic             out_valid_reg;
    mpg_pkg::result_t result_reg, result_next;

    logic            upd;
    logic            growing, pressure, was_pressure, restore;
    mpg_pkg::ret_t   ret_lim;
    logic [mpg_pkg::TIME_BITS:0] rec_elapsed, chg_elapsed;
    logic            recovery_done, change_waited;
    mpg_pkg::bytes_t now_cap, target, quarter, inc, cap_plus, cand, delta;
    logic            t_above;
    logic [mpg_pkg::BYTE_BITS+3:0] delta_x10;
    logic            big_change;

    assign upd = in_valid && adv;

    always_comb
    begin
        mem_flag_next  = pin.tag.free_valid ? pin.tag.mem_low : mem_flag_reg;
        growing        = swap_flag_reg ? pin.tag.grow_sustain : pin.tag.grow_entry;
        swap_flag_next = pin.tag.swap_present ? growing : swap_flag_reg;
        pressure       = mem_flag_next || swap_flag_next;
        was_pressure   = mem_flag_reg || swap_flag_reg;

        // borrow bit set means the clock went backwards
        rec_elapsed   = {1'b0, pin.tag.now_ms} - {1'b0, recovery_time_reg};
        recovery_done = recovery_valid_reg && !rec_elapsed[mpg_pkg::TIME_BITS] &&
                        (rec_elapsed[mpg_pkg::TIME_BITS-1:0] >= mpg_pkg::RECOVERY_TICKS);

        count_next          = count_reg;
        retention_next      = retention_reg;
        recovery_valid_next = recovery_valid_reg;
        recovery_time_next  = recovery_time_reg;
        restore             = 1'b0;
        ret_lim             = mpg_pkg::RET_25;

        if (pressure)
        begin
            if (count_reg < mpg_pkg::CNT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end
            ret_lim = (count_next >= mpg_pkg::CNT_MAX) ? mpg_pkg::RET_10 : mpg_pkg::RET_25;
            if (retention_reg > ret_lim)
            begin
                retention_next = ret_lim;
            end
            recovery_valid_next = 1'b0;
            recovery_time_next  = '0;
        end
        else if (pin.tag.free_valid)
        begin
            count_next          = '0;
            recovery_valid_next = 1'b1;
            if (!recovery_valid_reg)
            begin
                recovery_time_next = pin.tag.now_ms;
            end
            if (recovery_done)
            begin
                restore            = 1'b1;
                recovery_time_next = pin.tag.now_ms;
                if (retention_reg < mpg_pkg::RET_25)
                begin
                    retention_next = mpg_pkg::RET_25;
                end
                else if (retention_reg < mpg_pkg::RET_50)
                begin
                    retention_next = mpg_pkg::RET_50;
                end
                else
                begin
                    retention_next = mpg_pkg::RET_100;
                end
            end
        end
    end

    always_comb
    begin
        now_cap = cap_reg;
        target  = pin.target;
        t_above = target > now_cap;
        // a rise is at most a quarter, saturated at all ones
        quarter  = now_cap >> 2;
        inc      = (quarter < ~now_cap) ? quarter : ~now_cap;
        cap_plus = now_cap + inc;

        if (t_above)
        begin
            if (!restore)
            begin
                cand  = now_cap;
                delta = '0;
            end
            else if ((target - now_cap) <= inc)
            begin
                cand  = target;
                delta = target - now_cap;
            end
            else
            begin
                cand  = cap_plus;
                delta = inc;
            end
        end
        else
        begin
            cand  = target;
            delta = now_cap - target;
        end

        // delta > floor(cap / 10)  <=>  10 * delta > cap
        delta_x10  = {delta, 3'b000} + {2'b00, delta, 1'b0};
        big_change = delta_x10 > {4'b0000, now_cap};

        chg_elapsed   = {1'b0, pin.tag.now_ms} - {1'b0, change_time_reg};
        change_waited = !change_valid_reg ||
                        (!chg_elapsed[mpg_pkg::TIME_BITS] &&
                         (chg_elapsed[mpg_pkg::TIME_BITS-1:0] >= mpg_pkg::CHANGE_TICKS));

        cap_next          = cap_reg;
        change_valid_next = change_valid_reg;
        change_time_next  = change_time_reg;
        if (big_change && change_waited)
        begin
            cap_next          = cand;
            change_valid_next = 1'b1;
            change_time_next  = pin.tag.now_ms;
        end

        result_next.memory_pressure   = mem_flag_next;
        result_next.swap_pressure     = swap_flag_next;
        result_next.memory_notice     = pressure && !was_pressure;
        result_next.swap_notice       = swap_flag_next && !swap_flag_reg;
        result_next.retention_percent = retention_next;
        result_next.effective_cap     = cap_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_flag_reg       <= 1'b0;
            swap_flag_reg      <= 1'b0;
            count_reg          <= '0;
            retention_reg      <= mpg_pkg::RET_100;
            recovery_valid_reg <= 1'b0;
            recovery_time_reg  <= '0;
            change_valid_reg   <= 1'b0;
            change_time_reg    <= '0;
            cap_reg            <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= in_valid;
            end
            if (cap_load)
            begin
                cap_reg <= cap_load_value;
            end
            else if (upd)
            begin
                cap_reg <= cap_next;
            end
            if (upd)
            begin
                mem_flag_reg       <= mem_flag_next;
                swap_flag_reg      <= swap_flag_next;
                count_reg          <= count_next;
                retention_reg      <= retention_next;
                recovery_valid_reg <= recovery_valid_next;
                recovery_time_reg  <= recovery_time_next;
                change_valid_reg   <= change_valid_next;
                change_time_reg    <= change_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    // apart from a cap load, the cap climbs only on a restore step
    a_cap_rise_on_restore: assert property (@(posedge clk) disable iff (!rst_n)
        upd && !cap_load && !restore |-> cap_next <= cap_reg)
        else $error("cap rose without a restore step");

    a_pressure_cuts_retention: assert property (@(posedge clk) disable iff (!rst_n)
        upd && pressure |=> retention_reg <= mpg_pkg::RET_25)
        else $error("retention above 25 percent under pressure");

    a_change_stamps_timer: assert property (@(posedge clk) disable iff (!rst_n)
        upd && !cap_load && cap_next != cap_reg
        |=> change_valid_reg && change_time_reg == $past(pin.tag.now_ms))
        else $error("cap changed without stamping the change timer");

    a_result_matches_cap: assert property (@(posedge clk) disable iff (!rst_n)
        upd && !cap_load |=> out_valid && out_result.effective_cap == cap_reg)
        else $error("reported cap differs from held cap");

endmodule

// ===== hw/rtl/memory_pressure_governor.sv =====
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tdata: samples, s_tuser: presence flags
// m_*       out  m_tvalid / m_tready    m_tdata: pressure flags, retention, cap
// cfg_*     in   cfg_we                 cfg_index, cfg_data: register write
//
// One sample per cycle sustained while m_tready keeps the result register drained; m_tvalid for a result
// rises after its transaction has passed the seven-stage sample pipeline (saturating sum, divide by 5
// in shift-add steps, swap growth check) and the registered governor update.
// Reset clears config and cap to 0, flags and timers to 0, retention to 100.
// m_tready low while a result waits freezes the whole pipeline; s_tready is high
// whenever the result register is empty or being drained.
module memory_pressure_governor (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // free_bytes, swap_used_bytes, retained_total, now_ms
    input  logic [mpg_pkg::IN_TDATA_BITS-1:0]      s_tdata,
    // free_valid, swap_present
    input  logic [1:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // memory_pressure, swap_pressure, memory_notice, swap_notice,
    // retention_percent, effective_cap, zero fill
    output logic [mpg_pkg::OUT_TDATA_BITS-1:0]     m_tdata,
    input  logic                                   cfg_we,
    input  logic [mpg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [mpg_pkg::BYTE_BITS-1:0]          cfg_data
);

    localparam int B = mpg_pkg::BYTE_BITS;
    localparam int T = mpg_pkg::TIME_BITS;

    mpg_pkg::cfg_t    cfg_reg;
    mpg_pkg::sample_t sample;
    mpg_pkg::prep_t   prep;
    mpg_pkg::result_t result;
    logic             prep_valid;
    logic             out_valid;
    logic             adv;
    logic             cap_load;

    assign adv      = !out_valid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid;
    assign cap_load = cfg_we && (cfg_index == mpg_pkg::CFG_INITIAL_CAP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mpg_pkg::CFG_PHYSICAL: cfg_reg.physical    <= cfg_data;
                mpg_pkg::CFG_RESERVE:  cfg_reg.reserve     <= cfg_data;
                mpg_pkg::CFG_TOTAL:    cfg_reg.total       <= cfg_data;
                mpg_pkg::CFG_FLOOR:    cfg_reg.floor_bytes <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        sample.free_valid      = s_tuser[0];
        sample.swap_present    = s_tuser[1];
        sample.free_bytes      = s_tdata[B-1:0];
        sample.swap_used_bytes = s_tdata[2*B-1:B];
        sample.retained_total  = s_tdata[3*B-1:2*B];
        sample.now_ms          = s_tdata[3*B+T-1:3*B];
    end

    mpg_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_sample (sample),
        .cfg       (cfg_reg),
        .out_valid (prep_valid),
        .out_prep  (prep)
    );

    mpg_state u_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .in_valid       (prep_valid),
        .pin            (prep),
        .cap_load       (cap_load),
        .cap_load_value (cfg_data),
        .out_valid      (out_valid),
        .out_result     (result)
    );

    assign m_tdata = {{mpg_pkg::OUT_PAD_BITS{1'b0}},
                      result.effective_cap,
                      result.retention_percent,
                      result.swap_notice,
                      result.memory_notice,
                      result.swap_pressure,
                      result.memory_pressure};

endmodule
